// ===== hdl/lens_distortion_map_top_macros.svh =====
// Assertion macros shared by the lens distortion map RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LENS_DISTORTION_MAP_TOP_MACROS_SVH
`define LENS_DISTORTION_MAP_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LDM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LDM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ldm_pkg.sv =====
// Package for the lens distortion map: payload types, register indexes and
// the saturating fixed-point helper. No dependencies.
`default_nettype none

package ldm_pkg;

    typedef struct packed {
        logic [9:0] pixel_row;
        logic [9:0] pixel_col;
    } ldm_in_t;

    typedef struct packed {
        logic [9:0] dest_row;
        logic [9:0] dest_col;
        logic [9:0] source_row;
        logic [9:0] source_col;
    } ldm_out_t;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_X    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_Y    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K1  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K2  = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIAL_K3  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TANGENTIAL = 4'd7;

    localparam logic [31:0] FOCAL_RESET  = 32'd32768000;
    localparam logic [31:0] CENTER_RESET = 32'd33554432;

    localparam int IMAGE_WIDTH_DEF  = 1024;
    localparam int IMAGE_HEIGHT_DEF = 1024;

    localparam int QUO_BITS = 62;

    localparam logic signed [63:0] QLIM    = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(QLIM))
            return QLIM;
        else if (s < -65'(QLIM))
            return -QLIM;
        else
            return 64'(s);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ldm_qmul.sv =====
// Two-stage signed Q.32 multiplier with truncation toward zero and saturation.
// Depends on ldm_pkg for the saturation limit.
`default_nettype none

module ldm_qmul
    import ldm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);

    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] p00_next;
    logic [63:0] p01_next;
    logic [63:0] p10_next;
    logic [63:0] p11_next;
    logic [63:0] p00_reg;
    logic [63:0] p01_reg;
    logic [63:0] p10_reg;
    logic [63:0] p11_reg;
    logic        neg_reg;
    logic [33:0] mid;
    logic [63:0] hi;
    logic [63:0] mag;
    logic signed [63:0] p_next;
    logic signed [63:0] p_reg;

    assign ua = a[63] ? 64'(-a) : 64'(a);
    assign ub = b[63] ? 64'(-b) : 64'(b);

    assign p00_next = ua[31:0] * ub[31:0];
    assign p01_next = ua[31:0] * ub[63:32];
    assign p10_next = ua[63:32] * ub[31:0];
    assign p11_next = ua[63:32] * ub[63:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
            neg_reg <= a[63] ^ b[63];
        end
    end

    assign mid = 34'(p00_reg[63:32]) + 34'(p01_reg[31:0]) + 34'(p10_reg[31:0]);
    assign hi  = p11_reg + 64'(p01_reg[63:32]) + 64'(p10_reg[63:32]) + 64'(mid[33:32]);
    assign mag = (|hi[63:30]) ? 64'(QLIM) : {2'b00, hi[29:0], mid[31:0]};
    assign p_next = neg_reg ? -$signed(mag) : $signed(mag);

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hdl/ldm_norm.sv =====
// Normalisation of a pixel coordinate: (pixel - centre) / focal in Q.32,
// through a one-bit-per-stage pipelined divider. Depends on ldm_pkg.
`default_nettype none

module ldm_norm
    import ldm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ldm_in_t            in_pix,
    input  logic [31:0]        focal_x,
    input  logic [31:0]        focal_y,
    input  logic [31:0]        center_x,
    input  logic [31:0]        center_y,
    output logic               out_valid,
    output ldm_in_t            out_pix,
    output logic signed [63:0] x,
    output logic signed [63:0] y
);

    typedef struct packed {
        logic [31:0]         rem;
        logic [QUO_BITS-1:0] quo;
        logic [29:0]         mlo;
        logic                neg;
        logic                sat;
    } div_state_t;

    div_state_t xs_reg [0:QUO_BITS];
    div_state_t ys_reg [0:QUO_BITS];
    ldm_in_t    pix_reg [0:QUO_BITS];
    logic       valid_reg [0:QUO_BITS];
    logic [31:0] dx;
    logic [31:0] dy;
    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    ldm_in_t    fpix_reg;
    logic       fvalid_reg;

    function automatic div_state_t prep(input logic [9:0] pix, input logic [31:0] center,
                                        input logic [31:0] d);
        div_state_t res;
        logic signed [33:0] diff;
        logic [32:0] m;
        diff = $signed({8'b0, pix, 16'b0}) - $signed({2'b0, center});
        m = diff[33] ? 33'(-diff) : 33'(diff);
        res.rem = {29'b0, m[32:30]};
        res.quo = '0;
        res.mlo = m[29:0];
        res.neg = diff[33];
        res.sat = ({29'b0, m} >= {d, 30'b0});
        return res;
    endfunction

    function automatic div_state_t step(input div_state_t s, input logic nb,
                                        input logic [31:0] d, input logic [5:0] pos);
        div_state_t res;
        logic [32:0] t;
        res = s;
        t = {s.rem, nb};
        if (t >= {1'b0, d})
        begin
            res.rem = 32'(t - {1'b0, d});
            res.quo[pos] = 1'b1;
        end
        else
        begin
            res.rem = t[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [63:0] finish(input div_state_t s);
        logic [63:0] mag;
        mag = s.sat ? 64'(QLIM) : {2'b00, s.quo};
        return s.neg ? -$signed(mag) : $signed(mag);
    endfunction

    assign dx = (focal_x == 32'd0) ? 32'd1 : focal_x;
    assign dy = (focal_y == 32'd0) ? 32'd1 : focal_y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_reg[0]  <= prep(in_pix.pixel_col, center_x, dx);
            ys_reg[0]  <= prep(in_pix.pixel_row, center_y, dy);
            pix_reg[0] <= in_pix;
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_div
        localparam int Pos = QUO_BITS - 1 - k;
        logic nbx;
        logic nby;
        if (Pos >= 32)
        begin : g_bit
            assign nbx = xs_reg[k].mlo[Pos-32];
            assign nby = ys_reg[k].mlo[Pos-32];
        end
        else
        begin : g_zero
            assign nbx = 1'b0;
            assign nby = 1'b0;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xs_reg[k+1]  <= step(xs_reg[k], nbx, dx, 6'(Pos));
                ys_reg[k+1]  <= step(ys_reg[k], nby, dy, 6'(Pos));
                pix_reg[k+1] <= pix_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QUO_BITS; i++)
                valid_reg[i] <= 1'b0;
            fvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= QUO_BITS; i++)
                valid_reg[i] <= valid_reg[i-1];
            fvalid_reg <= valid_reg[QUO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= finish(xs_reg[QUO_BITS]);
            y_reg    <= finish(ys_reg[QUO_BITS]);
            fpix_reg <= pix_reg[QUO_BITS];
        end
    end

    assign out_valid = fvalid_reg;
    assign out_pix   = fpix_reg;
    assign x         = x_reg;
    assign y         = y_reg;

endmodule

`default_nettype wire

// ===== hdl/lens_distortion_map_top.sv =====
// Lens distortion map, top level: configuration registers, distortion
// pipeline and output skid stage. Depends on ldm_pkg, ldm_norm, ldm_qmul.
//
// Usage. Each input transaction on in_valid/in_ready carries one undistorted
// pixel (row, column). The block maps it through the five-coefficient
// Brown-Conrady model and, when the source pixel falls inside the image,
// delivers one output transaction on out_valid/out_ready with the input
// pixel and the source pixel to sample; otherwise the pixel yields nothing.
// From input acceptance to out_valid a pixel passes through the normalising
// divider (one quotient bit per stage), the multiply and add pipeline and
// the output register. One transaction is accepted every cycle while the
// skid register is empty.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at once and
// must be made while no transaction is in flight; the block does not enforce it.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, one extra result is held in a skid register;
// once it is occupied the whole pipeline and in_ready hold until the output
// is taken, so nothing is lost or repeated.
`default_nettype none
`include "lens_distortion_map_top_macros.svh"

module lens_distortion_map_top
    import ldm_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ldm_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ldm_out_t               out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PipeDepth = 18;

    logic [31:0] focal_x_reg;
    logic [31:0] focal_y_reg;
    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;
    logic [31:0] radial_k1_reg;
    logic [31:0] radial_k2_reg;
    logic [31:0] radial_k3_reg;
    logic [63:0] tangential_reg;

    logic adv;
    logic norm_valid;
    ldm_in_t norm_pix;
    logic signed [63:0] x;
    logic signed [63:0] y;

    logic signed [63:0] k1q;
    logic signed [63:0] k2q;
    logic signed [63:0] k3q;
    logic signed [63:0] p1q;
    logic signed [63:0] p2q;
    logic signed [63:0] p1x2;
    logic signed [63:0] p2x2;
    logic signed [63:0] fxq;
    logic signed [63:0] fyq;
    logic signed [63:0] cxq;
    logic signed [63:0] cyq;

    logic signed [63:0] x2;
    logic signed [63:0] y2;
    logic signed [63:0] xy;
    logic signed [63:0] r2_reg;
    logic signed [63:0] dx2_reg;
    logic signed [63:0] dy2_reg;
    logic signed [63:0] tx1;
    logic signed [63:0] ty2;
    logic signed [63:0] tx_reg;
    logic signed [63:0] ty_reg;
    logic signed [63:0] r4;
    logic signed [63:0] a1;
    logic signed [63:0] tx2;
    logic signed [63:0] ty1;
    logic signed [63:0] r6;
    logic signed [63:0] a2;
    logic signed [63:0] b1_reg;
    logic signed [63:0] a3;
    logic signed [63:0] s23_reg;
    logic signed [63:0] rad_reg;
    logic signed [63:0] xr;
    logic signed [63:0] yr;
    logic signed [63:0] ex_reg;
    logic signed [63:0] ey_reg;
    logic signed [63:0] xd_reg;
    logic signed [63:0] yd_reg;
    logic signed [63:0] pu;
    logic signed [63:0] pv;
    logic signed [63:0] u_reg;
    logic signed [63:0] v_reg;

    logic signed [63:0] r2_dly_reg  [0:1];
    logic signed [63:0] a2_dly_reg  [0:1];
    logic signed [63:0] b1_dly_reg  [0:3];
    logic signed [63:0] x_dly_reg   [0:10];
    logic signed [63:0] y_dly_reg   [0:10];
    logic signed [63:0] tx1_dly_reg [0:8];
    logic signed [63:0] ty1_dly_reg [0:6];
    logic signed [63:0] tx2_dly_reg [0:7];
    logic signed [63:0] ty2_dly_reg [0:9];
    logic               vld_dly_reg [0:PipeDepth-1];
    ldm_in_t            pix_dly_reg [0:PipeDepth-1];

    logic     ok_u;
    logic     ok_v;
    logic     push;
    logic     take;
    ldm_out_t res;
    ldm_out_t out_reg;
    ldm_out_t skid_reg;
    logic     out_valid_reg;
    logic     skid_valid_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg    <= FOCAL_RESET;
            focal_y_reg    <= FOCAL_RESET;
            center_x_reg   <= CENTER_RESET;
            center_y_reg   <= CENTER_RESET;
            radial_k1_reg  <= '0;
            radial_k2_reg  <= '0;
            radial_k3_reg  <= '0;
            tangential_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FOCAL_X:    focal_x_reg    <= cfg_data[31:0];
                REG_FOCAL_Y:    focal_y_reg    <= cfg_data[31:0];
                REG_CENTER_X:   center_x_reg   <= cfg_data[31:0];
                REG_CENTER_Y:   center_y_reg   <= cfg_data[31:0];
                REG_RADIAL_K1:  radial_k1_reg  <= cfg_data[31:0];
                REG_RADIAL_K2:  radial_k2_reg  <= cfg_data[31:0];
                REG_RADIAL_K3:  radial_k3_reg  <= cfg_data[31:0];
                REG_TANGENTIAL: tangential_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Coefficients are lifted from Q4.28 and Q16.16 into Q.32.
    assign k1q  = {{28{radial_k1_reg[31]}}, radial_k1_reg, 4'b0};
    assign k2q  = {{28{radial_k2_reg[31]}}, radial_k2_reg, 4'b0};
    assign k3q  = {{28{radial_k3_reg[31]}}, radial_k3_reg, 4'b0};
    assign p1q  = {{28{tangential_reg[31]}}, tangential_reg[31:0], 4'b0};
    assign p2q  = {{28{tangential_reg[63]}}, tangential_reg[63:32], 4'b0};
    assign p1x2 = {{27{tangential_reg[31]}}, tangential_reg[31:0], 5'b0};
    assign p2x2 = {{27{tangential_reg[63]}}, tangential_reg[63:32], 5'b0};
    assign fxq  = {16'b0, focal_x_reg, 16'b0};
    assign fyq  = {16'b0, focal_y_reg, 16'b0};
    assign cxq  = {16'b0, center_x_reg, 16'b0};
    assign cyq  = {16'b0, center_y_reg, 16'b0};

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    ldm_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .in_pix    (in_data),
        .focal_x   (focal_x_reg),
        .focal_y   (focal_y_reg),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .out_valid (norm_valid),
        .out_pix   (norm_pix),
        .x         (x),
        .y         (y)
    );

    ldm_qmul u_x2  (.clk(clk), .en(adv), .a(x),              .b(x),       .p(x2));
    ldm_qmul u_y2  (.clk(clk), .en(adv), .a(y),              .b(y),       .p(y2));
    ldm_qmul u_xy  (.clk(clk), .en(adv), .a(x),              .b(y),       .p(xy));
    ldm_qmul u_tx1 (.clk(clk), .en(adv), .a(p1x2),           .b(xy),      .p(tx1));
    ldm_qmul u_ty2 (.clk(clk), .en(adv), .a(p2x2),           .b(xy),      .p(ty2));
    ldm_qmul u_r4  (.clk(clk), .en(adv), .a(r2_reg),         .b(r2_reg),  .p(r4));
    ldm_qmul u_a1  (.clk(clk), .en(adv), .a(k1q),            .b(r2_reg),  .p(a1));
    ldm_qmul u_tx2 (.clk(clk), .en(adv), .a(p2q),            .b(tx_reg),  .p(tx2));
    ldm_qmul u_ty1 (.clk(clk), .en(adv), .a(p1q),            .b(ty_reg),  .p(ty1));
    ldm_qmul u_r6  (.clk(clk), .en(adv), .a(r4),             .b(r2_dly_reg[1]), .p(r6));
    ldm_qmul u_a2  (.clk(clk), .en(adv), .a(k2q),            .b(r4),      .p(a2));
    ldm_qmul u_a3  (.clk(clk), .en(adv), .a(k3q),            .b(r6),      .p(a3));
    ldm_qmul u_xr  (.clk(clk), .en(adv), .a(x_dly_reg[10]),  .b(rad_reg), .p(xr));
    ldm_qmul u_yr  (.clk(clk), .en(adv), .a(y_dly_reg[10]),  .b(rad_reg), .p(yr));
    ldm_qmul u_pu  (.clk(clk), .en(adv), .a(fxq),            .b(xd_reg),  .p(pu));
    ldm_qmul u_pv  (.clk(clk), .en(adv), .a(fyq),            .b(yd_reg),  .p(pv));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_reg  <= sadd(x2, y2);
            dx2_reg <= sadd(x2, x2);
            dy2_reg <= sadd(y2, y2);
            tx_reg  <= sadd(r2_reg, dx2_reg);
            ty_reg  <= sadd(r2_reg, dy2_reg);
            b1_reg  <= sadd(ONE_Q32, a1);
            s23_reg <= sadd(a2_dly_reg[1], a3);
            rad_reg <= sadd(b1_dly_reg[3], s23_reg);
            ex_reg  <= sadd(xr, tx1_dly_reg[8]);
            ey_reg  <= sadd(yr, ty1_dly_reg[6]);
            xd_reg  <= sadd(ex_reg, tx2_dly_reg[7]);
            yd_reg  <= sadd(ey_reg, ty2_dly_reg[9]);
            u_reg   <= sadd(pu, cxq);
            v_reg   <= sadd(pv, cyq);

            r2_dly_reg[0]  <= r2_reg;
            a2_dly_reg[0]  <= a2;
            b1_dly_reg[0]  <= b1_reg;
            x_dly_reg[0]   <= x;
            y_dly_reg[0]   <= y;
            tx1_dly_reg[0] <= tx1;
            ty1_dly_reg[0] <= ty1;
            tx2_dly_reg[0] <= tx2;
            ty2_dly_reg[0] <= ty2;
            pix_dly_reg[0] <= norm_pix;
            r2_dly_reg[1]  <= r2_dly_reg[0];
            a2_dly_reg[1]  <= a2_dly_reg[0];
            for (int i = 1; i < 4; i++)
                b1_dly_reg[i] <= b1_dly_reg[i-1];
            for (int i = 1; i < 11; i++)
            begin
                x_dly_reg[i] <= x_dly_reg[i-1];
                y_dly_reg[i] <= y_dly_reg[i-1];
            end
            for (int i = 1; i < 9; i++)
                tx1_dly_reg[i] <= tx1_dly_reg[i-1];
            for (int i = 1; i < 7; i++)
                ty1_dly_reg[i] <= ty1_dly_reg[i-1];
            for (int i = 1; i < 8; i++)
                tx2_dly_reg[i] <= tx2_dly_reg[i-1];
            for (int i = 1; i < 10; i++)
                ty2_dly_reg[i] <= ty2_dly_reg[i-1];
            for (int i = 1; i < PipeDepth; i++)
                pix_dly_reg[i] <= pix_dly_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PipeDepth; i++)
                vld_dly_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_dly_reg[0] <= norm_valid;
            for (int i = 1; i < PipeDepth; i++)
                vld_dly_reg[i] <= vld_dly_reg[i-1];
        end
    end

    // A negative value above minus one truncates to pixel zero.
    assign ok_u = u_reg[63] ? ((u_reg[63:32] == 32'hFFFF_FFFF) && (u_reg[31:0] != 32'd0))
                            : (u_reg[63:32] < 32'(IMAGE_WIDTH));
    assign ok_v = v_reg[63] ? ((v_reg[63:32] == 32'hFFFF_FFFF) && (v_reg[31:0] != 32'd0))
                            : (v_reg[63:32] < 32'(IMAGE_HEIGHT));

    assign res.dest_row   = pix_dly_reg[PipeDepth-1].pixel_row;
    assign res.dest_col   = pix_dly_reg[PipeDepth-1].pixel_col;
    assign res.source_row = v_reg[63] ? 10'd0 : v_reg[41:32];
    assign res.source_col = u_reg[63] ? 10'd0 : u_reg[41:32];

    assign push = adv && vld_dly_reg[PipeDepth-1] && ok_u && ok_v;
    assign take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `LDM_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg,
                    "skid register holds a transaction while the output is empty")
    `LDM_ASSERT_NXT(a_stall_fills_skid, out_valid_reg && !out_ready && push, skid_valid_reg,
                    "result produced during an output stall was not parked")
    `LDM_ASSERT_NXT(a_skid_drains, skid_valid_reg && out_ready,
                    !skid_valid_reg && out_valid_reg,
                    "skid register did not move to the output when taken")

endmodule

`default_nettype wire

// ===== tb/source_map_checker.sv =====
// Watches the pixel and result channels of lens_distortion_map_top, predicts each source pixel
// and compares it with the result that the block delivers.
// Depends on ldm_pkg for the payload types and register indexes.
`default_nettype none

module source_map_checker
    import ldm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  ldm_in_t                in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  ldm_out_t               out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    typedef logic signed [63:0] q32_t;

    localparam q32_t SAT_MAX  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam q32_t UNITY    = 64'sh0000_0001_0000_0000;
    localparam int   WIDTH_PX = 1024;
    localparam int   HEIGHT_PX = 1024;

    logic [31:0] fx, fy, cx, cy, k1_reg, k2_reg, k3_reg;
    logic [63:0] tang_reg;
    ldm_out_t    expected_pixels[$];

    function automatic q32_t sat_sum(input q32_t a, input q32_t b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(SAT_MAX))
            return SAT_MAX;
        if (s < -65'(SAT_MAX))
            return -SAT_MAX;
        return s[63:0];
    endfunction

    function automatic q32_t fx_mul(input q32_t a, input q32_t b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        q32_t         r;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        prod = prod >> 32;
        if (prod >= (128'd1 << 62))
            r = SAT_MAX;
        else
            r = prod[63:0];
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic q32_t norm_coord(input logic [9:0] pix, input logic [31:0] centre,
                                        input logic [31:0] focal);
        q32_t        diff;
        logic [63:0] m;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] rem;
        q32_t        r;
        diff = $signed({38'd0, pix, 16'd0}) - $signed({32'd0, centre});
        m = (diff < 0) ? -diff : diff;
        d = (focal == 0) ? 64'd1 : {32'd0, focal};
        q = m / d;
        rem = m % d;
        if (q >= (64'd1 << 30))
            r = SAT_MAX;
        else
            r = (q << 32) + ((rem << 32) / d);
        return (diff < 0) ? -r : r;
    endfunction

    function automatic bit pixel_index(input q32_t v, input int limit, output logic [9:0] idx);
        q32_t ip;
        logic [63:0] mag;
        idx = '0;
        if (v >= 0)
            ip = v >>> 32;
        else
        begin
            mag = -v;
            if ((mag >> 32) != 0)
                return 0;
            ip = 0;
        end
        if (ip >= limit)
            return 0;
        idx = ip[9:0];
        return 1;
    endfunction

    function automatic bit map_pixel(input ldm_in_t px, output ldm_out_t res);
        q32_t k1, k2, k3, p1, p2, x, y, x2, y2, xy, r2, r4, r6, rad, xd, yd, u, v;
        logic [9:0] su, sv;
        res = '0;
        k1 = {{28{k1_reg[31]}}, k1_reg, 4'd0};
        k2 = {{28{k2_reg[31]}}, k2_reg, 4'd0};
        k3 = {{28{k3_reg[31]}}, k3_reg, 4'd0};
        p1 = {{28{tang_reg[31]}}, tang_reg[31:0], 4'd0};
        p2 = {{28{tang_reg[63]}}, tang_reg[63:32], 4'd0};
        x = norm_coord(px.pixel_col, cx, fx);
        y = norm_coord(px.pixel_row, cy, fy);
        x2 = fx_mul(x, x);
        y2 = fx_mul(y, y);
        xy = fx_mul(x, y);
        r2 = sat_sum(x2, y2);
        r4 = fx_mul(r2, r2);
        r6 = fx_mul(r4, r2);
        rad = sat_sum(sat_sum(UNITY, fx_mul(k1, r2)), sat_sum(fx_mul(k2, r4), fx_mul(k3, r6)));
        xd = sat_sum(sat_sum(fx_mul(x, rad), fx_mul(sat_sum(p1, p1), xy)),
                     fx_mul(p2, sat_sum(r2, sat_sum(x2, x2))));
        yd = sat_sum(sat_sum(fx_mul(y, rad), fx_mul(p1, sat_sum(r2, sat_sum(y2, y2)))),
                     fx_mul(sat_sum(p2, p2), xy));
        u = sat_sum(fx_mul({16'd0, fx, 16'd0}, xd), {16'd0, cx, 16'd0});
        v = sat_sum(fx_mul({16'd0, fy, 16'd0}, yd), {16'd0, cy, 16'd0});
        if (!pixel_index(u, WIDTH_PX, su))
            return 0;
        if (!pixel_index(v, HEIGHT_PX, sv))
            return 0;
        res.dest_row = px.pixel_row;
        res.dest_col = px.pixel_col;
        res.source_row = sv;
        res.source_col = su;
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ldm_out_t pred;
        ldm_out_t want;
        if (!rst_n)
        begin
            fx = FOCAL_RESET;
            fy = FOCAL_RESET;
            cx = CENTER_RESET;
            cy = CENTER_RESET;
            k1_reg = '0;
            k2_reg = '0;
            k3_reg = '0;
            tang_reg = '0;
            expected_pixels.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FOCAL_X:    fx = cfg_data[31:0];
                    REG_FOCAL_Y:    fy = cfg_data[31:0];
                    REG_CENTER_X:   cx = cfg_data[31:0];
                    REG_CENTER_Y:   cy = cfg_data[31:0];
                    REG_RADIAL_K1:  k1_reg = cfg_data[31:0];
                    REG_RADIAL_K2:  k2_reg = cfg_data[31:0];
                    REG_RADIAL_K3:  k3_reg = cfg_data[31:0];
                    REG_TANGENTIAL: tang_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (map_pixel(in_data, pred))
                    expected_pixels.insert(expected_pixels.size(), pred);
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected transaction: got %p", out_data);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data.dest_row !== want.dest_row
                        || out_data.dest_col !== want.dest_col
                        || out_data.source_row !== want.source_row
                        || out_data.source_col !== want.source_col)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Stimulus and verdict for lens_distortion_map_top: register settings, pixel streams with
// random idling and a long output hold-off. Depends on ldm_pkg and source_map_checker.
`default_nettype none

module testbench
    import ldm_pkg::*;
();

    localparam int STALL_LIMIT = 4000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    ldm_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    ldm_out_t               out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     pending;
    int                     send_idle = 19;
    int                     recv_idle = 66;
    bit                     hold_go = 0;
    int                     quiet_cycles = 0;

    always #6 clk = ~clk;

    lens_distortion_map_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    source_map_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        bit hold_done;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_pixel(input logic [9:0] row, input logic [9:0] col);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{pixel_row: row, pixel_col: col};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [31:0] fxv, input logic [31:0] fyv,
                                input logic [31:0] cxv, input logic [31:0] cyv,
                                input logic [31:0] k1, input logic [31:0] k2,
                                input logic [31:0] k3, input logic [63:0] tang);
        settle();
        write_reg(REG_FOCAL_X, {$urandom, fxv});
        write_reg(REG_FOCAL_Y, {$urandom, fyv});
        write_reg(REG_CENTER_X, {32'd0, cxv});
        write_reg(REG_CENTER_Y, {32'd0, cyv});
        write_reg(REG_RADIAL_K1, {32'd0, k1});
        write_reg(REG_RADIAL_K2, {32'd0, k2});
        write_reg(REG_RADIAL_K3, {32'd0, k3});
        write_reg(REG_TANGENTIAL, tang);
        write_reg(4'($urandom_range(8, 15)), {$urandom, $urandom});
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] signed_coeff(input int span);
        return 32'($urandom_range(2 * span) - span);
    endfunction

    task automatic corner_pixels();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
    endtask

    initial
    begin
        int sent;
        int row;
        int col;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        corner_pixels();
        send_pixel(10'd511, 10'd511);
        send_pixel(10'd600, 10'd300);

        load_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        corner_pixels();
        load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF);
        corner_pixels();
        load_setting(32'd65536, 32'd65536, 32'h0200_0000, 32'h0200_0000,
                     32'd0, 32'd0, 32'd0, 64'd0);
        corner_pixels();
        send_pixel(10'd512, 10'd511);
        send_pixel(10'd511, 10'd512);

        sent = 0;
        for (int ph = 0; ph < 7; ph++)
        begin
            load_setting($urandom_range(32'd200 << 16, 32'd900 << 16),
                         $urandom_range(32'd200 << 16, 32'd900 << 16),
                         $urandom_range(32'd400 << 16, 32'd620 << 16),
                         $urandom_range(32'd400 << 16, 32'd620 << 16),
                         signed_coeff(134217728), signed_coeff(33554432),
                         signed_coeff(8388608),
                         {signed_coeff(2684354), signed_coeff(2684354)});
            row = $urandom_range(1023);
            col = $urandom_range(1023);
            for (int n = 0; n < 225; n++)
            begin
                if (sent < 525)
                begin
                    send_idle = 19;
                    recv_idle = 66;
                end
                else if (sent < 1050)
                begin
                    send_idle = 66;
                    recv_idle = 19;
                end
                else
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                if (ph == 4 && n == 10)
                    hold_go = 1;
                if ($urandom_range(99) < 60)
                begin
                    col = (col + 1) % 1024;
                    if (col == 0)
                        row = (row + 1) % 1024;
                end
                else
                begin
                    row = $urandom_range(1023);
                    col = $urandom_range(1023);
                end
                send_pixel(row[9:0], col[9:0]);
                sent++;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/ldm_pkg.sv
hdl/ldm_qmul.sv
hdl/ldm_norm.sv
hdl/lens_distortion_map_top.sv
tb/source_map_checker.sv
tb/testbench.sv
